[design/vifa_pkg.sv]
// Package for the variadic integer fold ALU: default data width, command codes
// and the control structures between the sequencer and the shared iterative unit.
// No dependencies.
package vifa_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CMD_WIDTH  = 4;

    localparam logic [CMD_WIDTH-1:0] CMD_GT    = 4'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_LT    = 4'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_EQ    = 4'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_SUB   = 4'd3;
    localparam logic [CMD_WIDTH-1:0] CMD_ADD   = 4'd4;
    localparam logic [CMD_WIDTH-1:0] CMD_DIV   = 4'd5;
    localparam logic [CMD_WIDTH-1:0] CMD_MUL   = 4'd6;
    localparam logic [CMD_WIDTH-1:0] CMD_OR    = 4'd7;
    localparam logic [CMD_WIDTH-1:0] CMD_MOD   = 4'd8;
    localparam logic [CMD_WIDTH-1:0] CMD_SHIFT = 4'd9;

    typedef enum logic {
        UOP_MUL,
        UOP_DIV
    } t_unit_op;

    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_rsp;

endpackage

[design/vifa_if.sv]
// Valid/ready channel interfaces for the fold ALU: input items and result items.
// Depends on vifa_pkg for the default data width and command width.
interface vifa_in_if #(
    parameter int DW = vifa_pkg::DATA_WIDTH
) ();
    import vifa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CMD_WIDTH-1:0]  command;
    logic signed [DW-1:0]  operand;
    logic signed [DW-1:0]  second_operand;
    logic                  is_first;
    logic                  is_last;
    logic                  is_empty;

    modport source (
        output valid, command, operand, second_operand, is_first, is_last, is_empty,
        input  ready
    );
    modport sink (
        input  valid, command, operand, second_operand, is_first, is_last, is_empty,
        output ready
    );
endinterface

interface vifa_out_if #(
    parameter int DW = vifa_pkg::DATA_WIDTH
) ();
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] result_value;
    logic                 is_boolean;
    logic                 error_flag;

    modport source (
        output valid, result_value, is_boolean, error_flag,
        input  ready
    );
    modport sink (
        input  valid, result_value, is_boolean, error_flag,
        output ready
    );
endinterface

[design/vifa_iter_unit.sv]
// Shared iterative unit: restoring unsigned divide or shift-add multiply, one bit a cycle,
// both on one adder. Depends on vifa_pkg for the request and response structures.
module vifa_iter_unit #(
    parameter int DATA_WIDTH = vifa_pkg::DATA_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  vifa_pkg::t_unit_req     i_req,
    input  logic [DATA_WIDTH-1:0]   i_a,
    input  logic [DATA_WIDTH-1:0]   i_b,
    output vifa_pkg::t_unit_rsp     o_rsp,
    output logic [DATA_WIDTH-1:0]   o_low,
    output logic [DATA_WIDTH-1:0]   o_rem
);
    import vifa_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int CW = $clog2(DW);
    localparam int AW = DW + 2;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    t_unit_op      r_op, n_op;
    logic [DW-1:0] r_x, n_x;   // dividend turning into quotient, or multiplier
    logic [DW-1:0] r_y, n_y;   // divisor, or shifted multiplicand
    logic [DW-1:0] r_r, n_r;   // partial remainder, or product

    logic [DW:0]   w_rem_sh;
    logic [AW-1:0] w_opa, w_opb, w_sum;
    logic          w_sub, w_neg;

    // One adder serves both operations: subtract for the divide trial, add for the multiply.
    always_comb begin
        w_rem_sh = {r_r, r_x[DW-1]};
        w_sub    = (r_op == UOP_DIV);
        if (w_sub) begin
            w_opa = {1'b0, w_rem_sh};
            w_opb = {2'b00, r_y};
        end else begin
            w_opa = {2'b00, r_r};
            w_opb = r_x[0] ? {2'b00, r_y} : '0;
        end
        w_sum = w_opa + (w_sub ? ~w_opb : w_opb) + AW'(w_sub);
        w_neg = w_sum[AW-1];
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_x    = r_x;
        n_y    = r_y;
        n_r    = r_r;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_op   = i_req.op;
            n_x    = i_a;
            n_y    = i_b;
            n_r    = '0;
        end else if (r_busy) begin
            if (r_op == UOP_DIV) begin
                n_x = {r_x[DW-2:0], ~w_neg};
                n_r = w_neg ? w_rem_sh[DW-1:0] : w_sum[DW-1:0];
            end else begin
                n_x = r_x >> 1;
                n_y = r_y << 1;
                n_r = w_sum[DW-1:0];
            end
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(DW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_op  <= n_op;
        r_x   <= n_x;
        r_y   <= n_y;
        r_r   <= n_r;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_low      = (r_op == UOP_DIV) ? r_x : r_r;
    assign o_rem      = r_r;

endmodule

[design/variadic_integer_fold_alu.sv]
// Variadic integer fold ALU, top level. Depends on vifa_pkg, vifa_if and vifa_iter_unit.
// An accepted item is registered, decoded in S_EXEC and held in S_WAIT when it needs the
// shared iterative unit (divide, multiply and modulo), which works one bit per cycle; a
// result, for a last or an empty item, then passes S_EMIT into the output register.
// The input is ready only when idle, so a new item is taken only once the last one is
// through, and later if the output is held.
module variadic_integer_fold_alu #(
    parameter int DATA_WIDTH = vifa_pkg::DATA_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vifa_in_if.sink       i_item,
    vifa_out_if.source    o_result
);
    import vifa_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int SHW = $clog2(DW);
    localparam logic [DW-1:0] LP_MIN  = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] LP_ONES = '1;
    localparam logic [DW-1:0] LP_ONE  = DW'(1);
    localparam logic [DW-1:0] LP_DW   = DW'(DW);

    // The sequencer registers the item, then decodes it, optionally runs the shared unit,
    // and for a last or empty item hands the result to the output register.
    // Reset (synchronous, active low) clears the accumulator, the chain and error flags
    // and the output valid.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_EMIT
    } t_state;

    t_state               r_state, n_state;
    logic [CMD_WIDTH-1:0] r_cmd, n_cmd;
    logic [DW-1:0]        r_a, n_a;
    logic [DW-1:0]        r_b, n_b;
    logic                 r_first, n_first;
    logic                 r_last, n_last;
    logic                 r_empty, n_empty;

    // Fold state
    logic [DW-1:0]        r_acc, n_acc;
    logic                 r_chain_failed, n_chain_failed;
    logic                 r_error_seen, n_error_seen;

    // Pending result, waiting for the output register
    logic [DW-1:0]        r_res, n_res;
    logic                 r_res_isb, n_res_isb;
    logic                 r_res_err, n_res_err;

    // Output register
    logic                 r_out_valid, n_out_valid;
    logic [DW-1:0]        r_out_value, n_out_value;
    logic                 r_out_isb, n_out_isb;
    logic                 r_out_err, n_out_err;

    t_unit_req            w_req;
    t_unit_rsp            w_rsp;
    logic [DW-1:0]        w_ua, w_ub;
    logic [DW-1:0]        w_low, w_rem;

    logic [DW-1:0]        w_mag_a, w_mag_b, w_mag_acc;
    logic [DW-1:0]        w_k, w_quo, w_shift;
    logic signed [DW-1:0] w_sra;
    logic                 w_need, w_mod_bad;

    vifa_iter_unit #(
        .DATA_WIDTH (DW)
    ) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_ua),
        .i_b     (w_ub),
        .o_rsp   (w_rsp),
        .o_low   (w_low),
        .o_rem   (w_rem)
    );

    // Magnitudes for the unsigned divider; the most negative value maps onto itself,
    // which reads correctly as an unsigned magnitude.
    assign w_mag_a   = r_a[DW-1]   ? -r_a   : r_a;
    assign w_mag_b   = r_b[DW-1]   ? -r_b   : r_b;
    assign w_mag_acc = r_acc[DW-1] ? -r_acc : r_acc;
    assign w_mod_bad = (r_b == '0) || (r_a[DW-1] && r_b[DW-1]);

    // Arithmetic shift: a non-negative count shifts left, a negative one shifts right
    // with sign fill; counts of the data width or more saturate.
    always_comb begin
        w_k   = -r_b;
        w_sra = $signed(r_a) >>> w_k[SHW-1:0];
        if (!r_b[DW-1]) begin
            w_shift = (r_b >= LP_DW) ? '0 : (r_a << r_b[SHW-1:0]);
        end else begin
            w_shift = (w_k >= LP_DW) ? {DW{r_a[DW-1]}} : w_sra;
        end
    end

    // The quotient is negated when the signs of dividend and divisor differ.
    assign w_quo = (r_acc[DW-1] != r_a[DW-1]) ? -w_low : w_low;

    always_comb begin
        n_state        = r_state;
        n_cmd          = r_cmd;
        n_a            = r_a;
        n_b            = r_b;
        n_first        = r_first;
        n_last         = r_last;
        n_empty        = r_empty;
        n_acc          = r_acc;
        n_chain_failed = r_chain_failed;
        n_error_seen   = r_error_seen;
        n_res          = r_res;
        n_res_isb      = r_res_isb;
        n_res_err      = r_res_err;
        n_out_valid    = r_out_valid;
        n_out_value    = r_out_value;
        n_out_isb      = r_out_isb;
        n_out_err      = r_out_err;
        w_req.start    = 1'b0;
        w_req.op       = UOP_MUL;
        w_ua           = '0;
        w_ub           = '0;
        w_need         = 1'b0;

        // A taken result frees the output register; a load in S_EMIT overrides this.
        if (o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_cmd   = i_item.command;
                    n_a     = i_item.operand;
                    n_b     = i_item.second_operand;
                    n_first = i_item.is_first;
                    n_last  = i_item.is_last;
                    n_empty = i_item.is_empty;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_res_isb = 1'b0;
                n_res_err = 1'b0;
                n_res     = '0;
                if (r_empty) begin
                    // An empty list clears the fold state and emits its identity, or else an error.
                    n_acc          = '0;
                    n_chain_failed = 1'b0;
                    n_error_seen   = 1'b0;
                    case (r_cmd)
                        CMD_GT, CMD_LT, CMD_EQ: begin
                            n_res     = LP_ONE;
                            n_res_isb = 1'b1;
                        end
                        CMD_ADD, CMD_OR: n_res = '0;
                        CMD_DIV, CMD_MUL: n_res = LP_ONE;
                        default: n_res_err = 1'b1;
                    endcase
                    n_state = S_EMIT;
                end else begin
                    if (r_first) begin
                        n_chain_failed = 1'b0;
                        n_error_seen   = 1'b0;
                    end
                    case (r_cmd)
                        CMD_GT: begin
                            if (!r_first && !($signed(r_a) < $signed(r_acc))) begin
                                n_chain_failed = 1'b1;
                            end
                            n_acc = r_a;
                        end
                        CMD_LT: begin
                            if (!r_first && !($signed(r_acc) < $signed(r_a))) begin
                                n_chain_failed = 1'b1;
                            end
                            n_acc = r_a;
                        end
                        CMD_EQ: begin
                            if (r_first) begin
                                n_acc = r_a;
                            end else if (r_a != r_acc) begin
                                n_chain_failed = 1'b1;
                            end
                        end
                        CMD_SUB: n_acc = r_first ? r_a : (r_acc - r_a);
                        CMD_ADD: n_acc = r_first ? r_a : (r_acc + r_a);
                        CMD_OR:  n_acc = r_first ? r_a : (r_acc | r_a);
                        CMD_DIV: begin
                            if (r_first) begin
                                n_acc = r_a;
                            end else if ((r_a == '0) || (r_acc == LP_MIN && r_a == LP_ONES)) begin
                                // The accumulator keeps its value after a failed divide.
                                n_error_seen = 1'b1;
                            end else begin
                                w_need   = 1'b1;
                                w_req.op = UOP_DIV;
                                w_ua     = w_mag_acc;
                                w_ub     = w_mag_a;
                            end
                        end
                        CMD_MUL: begin
                            if (r_first) begin
                                n_acc = r_a;
                            end else begin
                                w_need   = 1'b1;
                                w_req.op = UOP_MUL;
                                w_ua     = r_acc;
                                w_ub     = r_a;
                            end
                        end
                        CMD_MOD: begin
                            // Only the last item of a modulo list matters.
                            if (r_last && !w_mod_bad) begin
                                w_need   = 1'b1;
                                w_req.op = UOP_DIV;
                                w_ua     = w_mag_a;
                                w_ub     = w_mag_b;
                            end
                        end
                        default: ;
                    endcase

                    case (r_cmd)
                        CMD_GT, CMD_LT, CMD_EQ: begin
                            n_res     = n_chain_failed ? '0 : LP_ONE;
                            n_res_isb = 1'b1;
                        end
                        CMD_SUB: n_res = r_first ? -r_a : n_acc;
                        CMD_ADD, CMD_MUL, CMD_OR: n_res = n_acc;
                        CMD_DIV: begin
                            n_res_err = n_error_seen;
                            n_res     = n_error_seen ? '0 : n_acc;
                        end
                        CMD_MOD: n_res_err = w_mod_bad;
                        CMD_SHIFT: n_res = w_shift;
                        default: n_res_err = 1'b1;
                    endcase

                    w_req.start = w_need;
                    if (w_need) begin
                        n_state = S_WAIT;
                    end else if (r_last) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_WAIT: begin
                if (w_rsp.done) begin
                    case (r_cmd)
                        CMD_DIV: begin
                            // An earlier failed divide in the list still forces a zero.
                            n_acc = w_quo;
                            n_res = r_error_seen ? '0 : w_quo;
                        end
                        CMD_MUL: begin
                            n_acc = w_low;
                            n_res = w_low;
                        end
                        default: begin
                            // Modulo with a non-negative result: a negative value against a positive modulus
                            // folds the remainder back into the range of the modulus.
                            if (!r_a[DW-1]) begin
                                n_res = w_rem;
                            end else begin
                                n_res = (w_rem != '0) ? (r_b - w_rem) : '0;
                            end
                        end
                    endcase
                    n_state = r_last ? S_EMIT : S_IDLE;
                end
            end

            S_EMIT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res;
                    n_out_isb   = r_res_isb;
                    n_out_err   = r_res_err;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_a         <= n_a;
        r_b         <= n_b;
        r_first     <= n_first;
        r_last      <= n_last;
        r_empty     <= n_empty;
        r_res       <= n_res;
        r_res_isb   <= n_res_isb;
        r_res_err   <= n_res_err;
        r_out_value <= n_out_value;
        r_out_isb   <= n_out_isb;
        r_out_err   <= n_out_err;
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_acc          <= '0;
            r_chain_failed <= 1'b0;
            r_error_seen   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_acc          <= n_acc;
            r_chain_failed <= n_chain_failed;
            r_error_seen   <= n_error_seen;
            r_out_valid    <= n_out_valid;
        end
    end

    assign i_item.ready          = (r_state == S_IDLE);
    assign o_result.valid        = r_out_valid;
    assign o_result.result_value = r_out_value;
    assign o_result.is_boolean   = r_out_isb;
    assign o_result.error_flag   = r_out_err;

    // An erroneous transaction always carries a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_value == '0))
        else $error("error transaction with non-zero value");

    // A predicate is 0 or 1 and never an error.
    a_bool_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_isb) |-> (!r_out_err && r_out_value[DW-1:1] == '0))
        else $error("boolean transaction out of range");

    // The shared unit only completes while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_WAIT))
        else $error("unit completed outside the wait state");

    // Waiting is only legal while the unit is busy or just completing.
    a_wait_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> (w_rsp.busy || w_rsp.done))
        else $error("sequencer waits on an idle unit");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for variadic_integer_fold_alu: a directed set of lists and then random
// ones, with results checked against a fold predictor in the bench. Needs vifa_pkg, vifa_if.
module tb_top;
    import vifa_pkg::*;

    localparam int DW           = DATA_WIDTH;
    localparam int CLK_PERIOD   = 20;
    localparam int RANDOM_ITEMS = 500;
    localparam int LONG_HOLD    = 500;
    localparam int TAIL_CYCLES  = 2 * DW + 8;
    localparam int MAX_REPORTS  = 10;
    localparam int WATCHDOG_NS  = 10_000_000;

    localparam logic [DW-1:0] WORD_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] WORD_MIN = {1'b1, {(DW-1){1'b0}}};

    // Command codes past the shift command, which the block must answer with an error.
    localparam logic [CMD_WIDTH-1:0] CMD_FIRST_UNUSED = 4'd10;
    localparam logic [CMD_WIDTH-1:0] CMD_LAST_UNUSED  = 4'd15;

    typedef struct {
        logic [CMD_WIDTH-1:0] command;
        logic [DW-1:0]        operand;
        logic [DW-1:0]        second;
        bit                   is_first;
        bit                   is_last;
        bit                   is_empty;
        bit                   drain_first;  // hold this item back until every result is in
    } t_fold_item;

    typedef struct {
        logic [DW-1:0] value;
        bit            is_bool;
        bit            err;
    } t_fold_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    vifa_in_if  #(.DW(DW)) item_if ();
    vifa_out_if #(.DW(DW)) res_if ();

    variadic_integer_fold_alu #(.DATA_WIDTH(DW)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_fold_item items_to_send[$];
    t_fold_res  awaited_folds[$];

    // Predictor state, mirroring the block's accumulator and flags.
    logic [DW-1:0] fold_acc     = '0;
    bit            chain_broken = 1'b0;
    bit            div_fault    = 1'b0;

    t_fold_item  on_wire;
    bit          drain_next = 1'b0;
    bit          calm       = 1'b0;
    bit          hold_req   = 1'b0;
    int unsigned send_gap   = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;
    int unsigned n_total    = 0;
    int unsigned n_accepted = 0;
    int unsigned n_results  = 0;
    int unsigned n_predicates = 0;
    int unsigned n_flagged  = 0;
    int unsigned n_holds    = 0;
    int unsigned n_mismatch = 0;

    // Modulo with a non-negative result; a zero modulus or two negative operands is a fault.
    function automatic logic [DW-1:0] floor_mod(input logic [DW-1:0] x, input logic [DW-1:0] m,
                                                output bit fault);
        logic [DW-1:0] nx, nm;
        logic [DW:0]   mag_x, mag_m, rem;
        nx    = -x;
        nm    = -m;
        mag_x = x[DW-1] ? {1'b0, nx} : {1'b0, x};
        mag_m = m[DW-1] ? {1'b0, nm} : {1'b0, m};
        fault = 1'b0;
        if (m == '0 || (x[DW-1] && m[DW-1])) begin
            fault = 1'b1;
            return '0;
        end
        if (!x[DW-1]) begin
            rem = mag_x % mag_m;
            return rem[DW-1:0];
        end
        rem = mag_x % mag_m;
        if (rem == '0)
            return '0;
        rem = mag_m - rem;
        return rem[DW-1:0];
    endfunction

    // Positive counts shift left, negative counts shift right with sign fill; large counts
    // saturate to zero or to the sign.
    function automatic logic [DW-1:0] arith_shift(input logic [DW-1:0] v, input logic [DW-1:0] c);
        logic [DW-1:0] k;
        if (!c[DW-1])
            return (c >= DW) ? '0 : (v << c);
        k = -c;
        if (k >= DW)
            return v[DW-1] ? '1 : '0;
        return $signed(v) >>> k;
    endfunction

    // Applies one accepted item to the predictor state and queues the result it causes, if any.
    task automatic predict_fold(input t_fold_item it);
        t_fold_res r;
        bit        fault;
        r.value   = '0;
        r.is_bool = 1'b0;
        r.err     = 1'b0;
        fault     = 1'b0;
        if (it.is_empty) begin
            // An empty list clears the state and answers at once: its identity, or an error.
            fold_acc     = '0;
            chain_broken = 1'b0;
            div_fault    = 1'b0;
            case (it.command)
                CMD_GT, CMD_LT, CMD_EQ: begin
                    r.value   = 1;
                    r.is_bool = 1'b1;
                end
                CMD_ADD, CMD_OR:  r.value = '0;
                CMD_DIV, CMD_MUL: r.value = 1;
                default:          r.err = 1'b1;
            endcase
            awaited_folds.push_back(r);
        end else begin
            if (it.is_first) begin
                chain_broken = 1'b0;
                div_fault    = 1'b0;
            end
            case (it.command)
                CMD_GT: begin
                    if (!it.is_first && !($signed(it.operand) < $signed(fold_acc)))
                        chain_broken = 1'b1;
                    fold_acc = it.operand;
                end
                CMD_LT: begin
                    if (!it.is_first && !($signed(fold_acc) < $signed(it.operand)))
                        chain_broken = 1'b1;
                    fold_acc = it.operand;
                end
                CMD_EQ: begin
                    if (it.is_first)
                        fold_acc = it.operand;
                    else if (it.operand != fold_acc)
                        chain_broken = 1'b1;
                end
                CMD_SUB: fold_acc = it.is_first ? it.operand : fold_acc - it.operand;
                CMD_ADD: fold_acc = it.is_first ? it.operand : fold_acc + it.operand;
                CMD_DIV: begin
                    // A faulting divide leaves the accumulator as it was.
                    if (it.is_first)
                        fold_acc = it.operand;
                    else if (it.operand == '0 || (fold_acc == WORD_MIN && it.operand == '1))
                        div_fault = 1'b1;
                    else
                        fold_acc = $signed(fold_acc) / $signed(it.operand);
                end
                CMD_MUL: fold_acc = it.is_first ? it.operand : fold_acc * it.operand;
                CMD_OR:  fold_acc = it.is_first ? it.operand : fold_acc | it.operand;
                default: ;
            endcase
            if (it.is_last) begin
                case (it.command)
                    CMD_GT, CMD_LT, CMD_EQ: begin
                        r.value   = chain_broken ? 0 : 1;
                        r.is_bool = 1'b1;
                    end
                    CMD_SUB: r.value = it.is_first ? -it.operand : fold_acc;
                    CMD_ADD, CMD_MUL, CMD_OR: r.value = fold_acc;
                    CMD_DIV: begin
                        if (div_fault)
                            r.err = 1'b1;
                        else
                            r.value = fold_acc;
                    end
                    CMD_MOD: begin
                        r.value = floor_mod(it.operand, it.second, fault);
                        r.err   = fault;
                    end
                    CMD_SHIFT: r.value = arith_shift(it.operand, it.second);
                    default:   r.err = 1'b1;
                endcase
                awaited_folds.push_back(r);
            end
        end
    endtask

    // Mostly short gaps, now and then a long one; none at all during a calm stretch.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Operand values biased towards the extremes and towards small numbers.
    function automatic logic [DW-1:0] rand_word();
        logic [DW-1:0] w;
        int unsigned   sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            case ($urandom_range(0, 4))
                0:       w = '0;
                1:       w = 1;
                2:       w = '1;
                3:       w = WORD_MAX;
                default: w = WORD_MIN;
            endcase
        end else if (sel < 5) begin
            w = $urandom_range(0, 40);
            w = w - 20;
        end else begin
            w = $urandom();
        end
        return w;
    endfunction

    function automatic logic [CMD_WIDTH-1:0] any_command();
        if ($urandom_range(0, 7) == 0)
            return CMD_WIDTH'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
        return CMD_WIDTH'($urandom_range(CMD_GT, CMD_SHIFT));
    endfunction

    task automatic add_item(input logic [CMD_WIDTH-1:0] cmd, input logic [DW-1:0] a,
                            input logic [DW-1:0] b, input bit fst, input bit lst, input bit emp);
        t_fold_item it;
        it.command     = cmd;
        it.operand     = a;
        it.second      = b;
        it.is_first    = fst;
        it.is_last     = lst;
        it.is_empty    = emp;
        it.drain_first = drain_next;
        drain_next     = 1'b0;
        items_to_send.push_back(it);
    endtask

    // A properly marked list. Chains are mostly monotone (or constant) so that many pass.
    task automatic add_list(input logic [CMD_WIDTH-1:0] cmd, input int len);
        logic [DW-1:0] v, b;
        bit            tidy;
        tidy = ($urandom_range(0, 3) != 0);
        v    = rand_word();
        for (int i = 0; i < len; i++) begin
            b = $urandom();
            if (cmd == CMD_MOD) begin
                b = rand_word();
            end else if (cmd == CMD_SHIFT && $urandom_range(0, 3) != 0) begin
                b = $urandom_range(0, 2 * DW + 16);
                b = b - (DW + 8);
            end else if (cmd == CMD_SHIFT) begin
                b = rand_word();
            end
            add_item(cmd, v, b, i == 0, i == len - 1, 1'b0);
            case (cmd)
                CMD_GT:  v = tidy ? v - $urandom_range(1, 1000) : rand_word();
                CMD_LT:  v = tidy ? v + $urandom_range(1, 1000) : rand_word();
                CMD_EQ:  v = tidy ? v : rand_word();
                default: v = rand_word();
            endcase
        end
    endtask

    // Sender: offers the next pending item once its gap has run out and keeps valid high
    // until the transaction completes.
    always @(posedge i_clk) begin
        bit offering;
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else begin
            offering = item_if.valid;
            if (item_if.valid && item_if.ready) begin
                predict_fold(on_wire);
                n_accepted++;
                if (n_accepted % 40 == 0)
                    calm = ($urandom_range(0, 2) == 0);
                if (n_accepted == 80 || n_accepted == 350)
                    hold_req = 1'b1;
                send_gap = pick_gap();
                offering = 1'b0;
            end
            if (!offering) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (items_to_send.size() != 0 &&
                             !(items_to_send[0].drain_first && awaited_folds.size() != 0)) begin
                    on_wire = items_to_send.pop_front();
                    item_if.command        <= on_wire.command;
                    item_if.operand        <= on_wire.operand;
                    item_if.second_operand <= on_wire.second;
                    item_if.is_first       <= on_wire.is_first;
                    item_if.is_last        <= on_wire.is_last;
                    item_if.is_empty       <= on_wire.is_empty;
                    offering = 1'b1;
                end
            end
            item_if.valid <= offering;
        end
    end

    // Receiver: random stalls, mostly short, plus long holds that back the block up to its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
                n_holds++;
            end
            if (hold_left != 0)
                hold_left--;
            else if (stall_left != 0)
                stall_left--;
            else if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            res_if.ready <= (hold_left == 0 && stall_left == 0);
        end
    end

    // Checker: each result transaction against the oldest awaited fold.
    always @(posedge i_clk) begin
        t_fold_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            n_results++;
            if (awaited_folds.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("result %0d arrived with nothing awaited: value %h bool %b error %b",
                             n_results, res_if.result_value, res_if.is_boolean,
                             res_if.error_flag);
            end else begin
                want = awaited_folds.pop_front();
                if (want.is_bool)
                    n_predicates++;
                if (want.err)
                    n_flagged++;
                if (res_if.result_value !== want.value || res_if.is_boolean !== want.is_bool ||
                    res_if.error_flag !== want.err) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("result %0d: expected value %h bool %b error %b, got %h %b %b",
                                 n_results, want.value, want.is_bool, want.err,
                                 res_if.result_value, res_if.is_boolean, res_if.error_flag);
                end
            end
        end
    end

    initial begin
        int unsigned pick, half;
        bit          mid_drained;
        logic [CMD_WIDTH-1:0] cmd;

        i_rst_n                = 1'b0;
        item_if.valid          = 1'b0;
        item_if.command        = '0;
        item_if.operand        = '0;
        item_if.second_operand = '0;
        item_if.is_first       = 1'b0;
        item_if.is_last        = 1'b0;
        item_if.is_empty       = 1'b0;
        res_if.ready           = 1'b0;

        // Empty lists answer whatever the marks say, including with is_last low.
        add_item(CMD_GT, WORD_MAX, '0, 1'b1, 1'b1, 1'b1);
        add_item(CMD_SUB, '1, '0, 1'b0, 1'b0, 1'b1);
        add_item(CMD_DIV, '0, '1, 1'b1, 1'b0, 1'b1);
        add_item(CMD_OR, WORD_MIN, '0, 1'b0, 1'b1, 1'b1);
        add_item(CMD_MOD, 5, 3, 1'b1, 1'b1, 1'b1);
        add_item(CMD_LAST_UNUSED, 1, 1, 1'b1, 1'b1, 1'b1);
        // A lone subtract negates, which wraps for the most negative value.
        add_item(CMD_SUB, WORD_MIN, '1, 1'b1, 1'b1, 1'b0);
        // Overflowing divide and divide by zero.
        add_item(CMD_DIV, WORD_MIN, '0, 1'b1, 1'b0, 1'b0);
        add_item(CMD_DIV, '1, '0, 1'b0, 1'b1, 1'b0);
        add_item(CMD_DIV, 7, '0, 1'b1, 1'b0, 1'b0);
        add_item(CMD_DIV, '0, '0, 1'b0, 1'b1, 1'b0);
        // A decreasing chain seeded at the top of the range must pass.
        add_item(CMD_GT, WORD_MAX, '0, 1'b1, 1'b0, 1'b0);
        add_item(CMD_GT, '0, '0, 1'b0, 1'b0, 1'b0);
        add_item(CMD_GT, WORD_MIN, '0, 1'b0, 1'b1, 1'b0);
        // Modulo sign cases and a zero modulus.
        add_item(CMD_MOD, -7, 3, 1'b1, 1'b1, 1'b0);
        add_item(CMD_MOD, 7, -3, 1'b1, 1'b1, 1'b0);
        add_item(CMD_MOD, -7, -3, 1'b1, 1'b1, 1'b0);
        add_item(CMD_MOD, 5, '0, 1'b1, 1'b1, 1'b0);
        // Shifts just below, at and beyond the word width.
        add_item(CMD_SHIFT, 1, DW - 1, 1'b1, 1'b1, 1'b0);
        add_item(CMD_SHIFT, WORD_MIN, -(DW + 8), 1'b1, 1'b1, 1'b0);
        add_item(CMD_SHIFT, 5, DW, 1'b1, 1'b1, 1'b0);
        // Wrapping multiply and add.
        add_item(CMD_MUL, WORD_MAX, '0, 1'b1, 1'b0, 1'b0);
        add_item(CMD_MUL, WORD_MAX, '0, 1'b0, 1'b1, 1'b0);
        add_item(CMD_ADD, WORD_MAX, '0, 1'b1, 1'b0, 1'b0);
        add_item(CMD_ADD, 1, '0, 1'b0, 1'b1, 1'b0);

        // The random part starts only once the directed results are all in, and pauses
        // once more half way through.
        n_total     = items_to_send.size() + RANDOM_ITEMS;
        half        = items_to_send.size() + RANDOM_ITEMS / 2;
        mid_drained = 1'b0;
        drain_next  = 1'b1;
        while (items_to_send.size() < n_total) begin
            if (!mid_drained && items_to_send.size() >= half) begin
                drain_next  = 1'b1;
                mid_drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                add_item(any_command(), $urandom(), $urandom(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'b1);
            end else if (pick < 86) begin
                cmd = CMD_WIDTH'($urandom_range(CMD_GT, CMD_SHIFT));
                if (cmd == CMD_MOD || cmd == CMD_SHIFT)
                    add_list(cmd, ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1);
                else
                    add_list(cmd, $urandom_range(1, 6));
            end else begin
                // Broken marks and commands changing mid-list.
                repeat ($urandom_range(1, 3))
                    add_item(any_command(), rand_word(), rand_word(), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'b0);
            end
        end
        n_total = items_to_send.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted != n_total)
            @(posedge i_clk);
        while (awaited_folds.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d items, checked %0d results (%0d predicates, %0d error answers)",
                 n_accepted, n_results, n_predicates, n_flagged);
        $display("long receiver holds: %0d, mismatches: %0d", n_holds, n_mismatch);
        if (n_mismatch == 0)
            $display("** variadic_integer_fold_alu: PASSED **");
        else
            $display("** variadic_integer_fold_alu: FAILED **");
        $finish;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("timeout with %0d results still awaited", awaited_folds.size());
        $display("** variadic_integer_fold_alu: FAILED **");
        $finish;
    end

endmodule
